>>> rtl/lav_pkg.sv
`timescale 1ns / 1ps
// Package for the look-at view matrix block: word sizes, beat structs,
// and the rounding and saturation helpers. No dependencies.
package lav_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NORM_BITS = 30;
  localparam int AX_W      = FRAC_BITS + 2;
  localparam int D_W       = WORD_BITS + 1;
  localparam int CR_W      = NORM_BITS + AX_W + 2;
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int RT_W      = NORM_BITS + 1;
  localparam int WIDE_W    = 2 * WORD_BITS + 3;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_BACK  = 2'd2;

  localparam logic signed [WIDE_W-1:0] RND_HALF =
    {{(WIDE_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [AX_W-1:0]      ax_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t up_x;
    word_t up_y;
    word_t up_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0] row_index;
    word_t      col0;
    word_t      col1;
    word_t      col2;
    word_t      col3;
    logic       last;
    logic       degenerate;
  } lav_out_t;

  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] up;
  } zside_t;

  typedef struct packed {
    word_t [2:0] eye;
    ax_t   [2:0] zc;
    logic        z_ok;
  } xside_t;

  function automatic word_t sat_word(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[WORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v + RND_HALF;
    return t >>> FRAC_BITS;
  endfunction

endpackage

>>> rtl/lav_scale.sv
`timescale 1ns / 1ps
// Two-stage power-of-two scaler: magnitudes and signs, then a shift that
// gives the largest magnitude exactly NORM_BITS bits. Uses lav_pkg.
module lav_scale import lav_pkg::*; #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][IN_W-1:0]          vec_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [2:0][NORM_BITS-1:0]     mag_o,
  output logic [2:0]                    neg_o,
  output logic                          nz_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int NW   = $clog2(IN_W + 1);
  localparam int SH_W = IN_W + NORM_BITS;

  logic [2:0][IN_W-1:0]      mag_d, mag_q;
  logic [2:0]                neg_d, neg_q;
  logic [IN_W-1:0]           mx_d, mx_q;
  logic                      vld1_q;
  logic [SIDE_W-1:0]         side1_q;
  logic [NW-1:0]             nbits;
  logic [2:0][NORM_BITS-1:0] mag2_d, mag2_q;
  logic [SH_W-1:0]           sh;
  logic                      vld2_q;
  logic                      nz2_q;
  logic [2:0]                neg2_q;
  logic [SIDE_W-1:0]         side2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = vec_i[k][IN_W-1];
      mag_d[k] = neg_d[k] ? (~vec_i[k] + IN_W'(1)) : vec_i[k];
    end
    mx_d = mag_d[0];
    if (mag_d[1] > mx_d) begin
      mx_d = mag_d[1];
    end
    if (mag_d[2] > mx_d) begin
      mx_d = mag_d[2];
    end
  end

  always_comb begin
    nbits = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mx_q[i]) begin
        nbits = NW'(i + 1);
      end
    end
    sh = '0;
    for (int k = 0; k < 3; k++) begin
      sh        = {mag_q[k], {NORM_BITS{1'b0}}} >> nbits;
      mag2_d[k] = sh[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      mx_q    <= mx_d;
      side1_q <= side_i;
      mag2_q  <= mag2_d;
      neg2_q  <= neg_q;
      nz2_q   <= (mx_q != '0);
      side2_q <= side1_q;
    end
  end

  assign valid_o = vld2_q;
  assign mag_o   = mag2_q;
  assign neg_o   = neg2_q;
  assign nz_o    = nz2_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/lav_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a side
// payload that travels alongside. Uses lav_pkg.
module lav_isqrt import lav_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [SQ_W-1:0]       v_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [SQ_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int STEPS = SQ_W / 2;
  localparam int V_W   = SQ_W + 1;

  logic [V_W-1:0]    rem_q  [STEPS];
  logic [V_W-1:0]    res_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic [STEPS-1:0]  vld_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    localparam int BP = 2 * (STEPS - 1 - k);
    logic [V_W-1:0]    rin, resin, trial, rnext, resnext;
    logic              vin;
    logic [SIDE_W-1:0] sin;

    if (k == 0) begin : g_first
      assign rin   = {1'b0, v_i};
      assign resin = '0;
      assign vin   = valid_i;
      assign sin   = side_i;
    end else begin : g_next
      assign rin   = rem_q[k-1];
      assign resin = res_q[k-1];
      assign vin   = vld_q[k-1];
      assign sin   = side_q[k-1];
    end

    always_comb begin
      trial = resin + (V_W'(1) << BP);
      if (rin >= trial) begin
        rnext   = rin - trial;
        resnext = (resin >> 1) + (V_W'(1) << BP);
      end else begin
        rnext   = rin;
        resnext = resin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rnext;
        res_q[k]  <= resnext;
        side_q[k] <= sin;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = res_q[STEPS-1][STEPS-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule

>>> rtl/lav_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes sharing one divisor, one
// quotient bit per stage, rounding added at the start and sign applied at the end. Uses lav_pkg.
module lav_div import lav_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2:0][NORM_BITS-1:0] mag_i,
  input  logic [2:0]                neg_i,
  input  logic                      ok_i,
  input  logic [RT_W-1:0]           len_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output ax_t  [2:0]                ax_o,
  output logic                      ok_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int NUM_W = NORM_BITS + FRAC_BITS + 1;
  localparam int R_W   = NUM_W + 1;
  localparam int Q_W   = FRAC_BITS + 1;

  logic [2:0][R_W-1:0] rem_q  [Q_W];
  logic [2:0][Q_W-1:0] quo_q  [Q_W];
  logic [RT_W-1:0]     len_q  [Q_W];
  logic [2:0]          neg_q  [Q_W];
  logic [SIDE_W-1:0]   side_q [Q_W];
  logic [Q_W-1:0]      ok_q;
  logic [Q_W-1:0]      vld_q;

  ax_t  [2:0]          ax_d, ax_q;
  logic                okf_q, vldf_q;
  logic [SIDE_W-1:0]   sidef_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int BP = Q_W - 1 - k;
    logic [2:0][R_W-1:0] rin, rout;
    logic [2:0][Q_W-1:0] qin, qout;
    logic [RT_W-1:0]     lin;
    logic [2:0]          nin;
    logic                oin, vin;
    logic [SIDE_W-1:0]   sin;
    logic [R_W-1:0]      trial;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          rin[j] = R_W'({mag_i[j], {FRAC_BITS{1'b0}}}) + R_W'(len_i >> 1);
        end
      end
      assign qin = '0;
      assign lin = len_i;
      assign nin = neg_i;
      assign oin = ok_i;
      assign vin = valid_i;
      assign sin = side_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = quo_q[k-1];
      assign lin = len_q[k-1];
      assign nin = neg_q[k-1];
      assign oin = ok_q[k-1];
      assign vin = vld_q[k-1];
      assign sin = side_q[k-1];
    end

    always_comb begin
      trial = R_W'(lin) << BP;
      for (int j = 0; j < 3; j++) begin
        if (rin[j] >= trial) begin
          rout[j] = rin[j] - trial;
          qout[j] = qin[j] | (Q_W'(1) << BP);
        end else begin
          rout[j] = rin[j];
          qout[j] = qin[j];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rout;
        quo_q[k]  <= qout;
        len_q[k]  <= lin;
        neg_q[k]  <= nin;
        ok_q[k]   <= oin;
        side_q[k] <= sin;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!ok_q[Q_W-1]) begin
        ax_d[j] = '0;
      end else if (neg_q[Q_W-1][j]) begin
        ax_d[j] = -$signed(AX_W'(quo_q[Q_W-1][j]));
      end else begin
        ax_d[j] = $signed(AX_W'(quo_q[Q_W-1][j]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en_i) begin
      vldf_q <= vld_q[Q_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q    <= ax_d;
      okf_q   <= ok_q[Q_W-1];
      sidef_q <= side_q[Q_W-1];
    end
  end

  assign valid_o = vldf_q;
  assign ax_o    = ax_q;
  assign ok_o    = okf_q;
  assign side_o  = sidef_q;

endmodule

>>> rtl/lav_norm.sv
`timescale 1ns / 1ps
// Vector normalizer pipeline: scale, squares, sum, square root, divide.
// Uses lav_pkg, lav_scale, lav_isqrt and lav_div.
module lav_norm import lav_pkg::*; #(
  parameter int IN_W   = 33,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][IN_W-1:0] vec_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output ax_t  [2:0]           ax_o,
  output logic                 ok_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int SQP_W = 2 * NORM_BITS;
  localparam int PK_W  = SIDE_W + 4 + 3 * NORM_BITS;

  logic                      s_vld, s_nz;
  logic [2:0][NORM_BITS-1:0] s_mag;
  logic [2:0]                s_neg;
  logic [SIDE_W-1:0]         s_side;

  logic [2:0][SQP_W-1:0]     sq_q;
  logic [PK_W-1:0]           pk1_q, pk2_q;
  logic                      vsq_q, vsum_q;
  logic [SQ_W-1:0]           sum_q;

  logic                      r_vld;
  logic [RT_W-1:0]           r_len;
  logic [PK_W-1:0]           r_pk;

  lav_scale #(.IN_W(IN_W), .SIDE_W(SIDE_W)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .vec_i   (vec_i),
    .side_i  (side_i),
    .valid_o (s_vld),
    .mag_o   (s_mag),
    .neg_o   (s_neg),
    .nz_o    (s_nz),
    .side_o  (s_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsq_q  <= 1'b0;
      vsum_q <= 1'b0;
    end else if (en_i) begin
      vsq_q  <= s_vld;
      vsum_q <= vsq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SQP_W'(s_mag[k]) * SQP_W'(s_mag[k]);
      end
      pk1_q <= {s_side, s_nz, s_neg, s_mag};
      sum_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
      pk2_q <= pk1_q;
    end
  end

  lav_isqrt #(.SIDE_W(PK_W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vsum_q),
    .v_i     (sum_q),
    .side_i  (pk2_q),
    .valid_o (r_vld),
    .root_o  (r_len),
    .side_o  (r_pk)
  );

  lav_div #(.SIDE_W(SIDE_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (r_vld),
    .mag_i   (r_pk[3*NORM_BITS-1:0]),
    .neg_i   (r_pk[3*NORM_BITS+2:3*NORM_BITS]),
    .ok_i    (r_pk[3*NORM_BITS+3]),
    .len_i   (r_len),
    .side_i  (r_pk[PK_W-1:PK_W-SIDE_W]),
    .valid_o (valid_o),
    .ax_o    (ax_o),
    .ok_o    (ok_o),
    .side_o  (side_o)
  );

endmodule

>>> rtl/look_at_view_matrix_top.sv
`timescale 1ns / 1ps
// Top level of the look-at view matrix pipeline and its row serializer.
// Uses lav_pkg, lav_norm and lav_scale.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  lav_in_t, one look-at request
//   out      output     out_valid_o/out_ready_i  lav_out_t, one matrix row
//
// Each request gives three row beats, so with a free output the single output
// port, not the pipeline, sets how often a new request can be taken.
// Reset empties every stage; it takes effect at once, with no clearing pass.
// When the row register is full and not drained, every stage holds.
module look_at_view_matrix_top import lav_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lav_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lav_out_t out_data_o
);

  logic                   adv;
  logic                   a_vld_q;
  logic [2:0][D_W-1:0]    a_d_q;
  zside_t                 a_side_q;

  logic                   z_vld, z_ok;
  ax_t  [2:0]             z_ax;
  logic [$bits(zside_t)-1:0] z_side;
  zside_t                 zs;
  xside_t                 us_in;

  logic                   u_vld, u_nz;
  logic [2:0][NORM_BITS-1:0] u_mag;
  logic [2:0]             u_neg;
  logic [$bits(xside_t)-1:0] u_side;
  xside_t                 us;

  logic                   c_vld_q;
  logic [2:0][CR_W-1:0]   c_cr_q;
  logic [2:0][CR_W-1:0]   c_cr_d;
  xside_t                 c_side_q;
  logic signed [CR_W-1:0] upn [3];

  logic                   x_vld, x_ok;
  ax_t  [2:0]             x_ax;
  logic [$bits(xside_t)-1:0] x_side;
  xside_t                 xs;

  word_t [2:0][2:0]       axes_d, axes_q, axes_e_q;
  word_t [2:0]            eye_d_q;
  logic                   deg_d_q, deg_e_q, deg_f_q;
  logic                   vld_d_q, vld_e_q, vld_f_q;
  logic signed [2*WORD_BITS-1:0] prod_q [3][3];
  word_t [2:0][3:0]       rows_f_d, rows_f_q;

  logic                   ser_vld_q;
  logic [1:0]             cnt_q;
  word_t [2:0][3:0]       ser_rows_q;
  logic                   ser_deg_q;
  logic                   out_fire, ser_done, load;

  assign out_fire = ser_vld_q & out_ready_i;
  assign ser_done = out_fire & (cnt_q == ROW_BACK);
  assign load     = vld_f_q & (~ser_vld_q | ser_done);
  assign adv      = ~vld_f_q | load;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_d_q[0] <= D_W'(in_data_i.eye_x) - D_W'(in_data_i.target_x);
      a_d_q[1] <= D_W'(in_data_i.eye_y) - D_W'(in_data_i.target_y);
      a_d_q[2] <= D_W'(in_data_i.eye_z) - D_W'(in_data_i.target_z);
      a_side_q.eye[0] <= in_data_i.eye_x;
      a_side_q.eye[1] <= in_data_i.eye_y;
      a_side_q.eye[2] <= in_data_i.eye_z;
      a_side_q.up[0]  <= in_data_i.up_x;
      a_side_q.up[1]  <= in_data_i.up_y;
      a_side_q.up[2]  <= in_data_i.up_z;
    end
  end

  lav_norm #(.IN_W(D_W), .SIDE_W($bits(zside_t))) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (a_vld_q),
    .vec_i   (a_d_q),
    .side_i  (a_side_q),
    .valid_o (z_vld),
    .ax_o    (z_ax),
    .ok_o    (z_ok),
    .side_o  (z_side)
  );

  assign zs        = zside_t'(z_side);
  assign us_in.eye = zs.eye;
  assign us_in.zc  = z_ax;
  assign us_in.z_ok = z_ok;

  lav_scale #(.IN_W(WORD_BITS), .SIDE_W($bits(xside_t))) u_scale_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (z_vld),
    .vec_i   (zs.up),
    .side_i  (us_in),
    .valid_o (u_vld),
    .mag_o   (u_mag),
    .neg_o   (u_neg),
    .nz_o    (u_nz),
    .side_o  (u_side)
  );

  assign us = xside_t'(u_side);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!u_nz) begin
        upn[k] = '0;
      end else if (u_neg[k]) begin
        upn[k] = -CR_W'($signed({1'b0, u_mag[k]}));
      end else begin
        upn[k] = CR_W'($signed({1'b0, u_mag[k]}));
      end
    end
    c_cr_d[0] = CR_W'(upn[1] * $signed(us.zc[2]) - upn[2] * $signed(us.zc[1]));
    c_cr_d[1] = CR_W'(upn[2] * $signed(us.zc[0]) - upn[0] * $signed(us.zc[2]));
    c_cr_d[2] = CR_W'(upn[0] * $signed(us.zc[1]) - upn[1] * $signed(us.zc[0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= u_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_cr_q   <= c_cr_d;
      c_side_q <= us;
    end
  end

  lav_norm #(.IN_W(CR_W), .SIDE_W($bits(xside_t))) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_vld_q),
    .vec_i   (c_cr_q),
    .side_i  (c_side_q),
    .valid_o (x_vld),
    .ax_o    (x_ax),
    .ok_o    (x_ok),
    .side_o  (x_side)
  );

  assign xs = xside_t'(x_side);

  always_comb begin
    logic signed [WIDE_W-1:0] t [3];
    t[0] = $signed(xs.zc[1]) * $signed(x_ax[2]) - $signed(xs.zc[2]) * $signed(x_ax[1]);
    t[1] = $signed(xs.zc[2]) * $signed(x_ax[0]) - $signed(xs.zc[0]) * $signed(x_ax[2]);
    t[2] = $signed(xs.zc[0]) * $signed(x_ax[1]) - $signed(xs.zc[1]) * $signed(x_ax[0]);
    for (int k = 0; k < 3; k++) begin
      axes_d[0][k] = {{(WORD_BITS-AX_W){x_ax[k][AX_W-1]}}, x_ax[k]};
      axes_d[1][k] = sat_word(rnd_shift(t[k]));
      axes_d[2][k] = {{(WORD_BITS-AX_W){xs.zc[k][AX_W-1]}}, xs.zc[k]};
    end
  end

  always_comb begin
    logic signed [WIDE_W-1:0] s;
    logic signed [WIDE_W-1:0] r;
    for (int k = 0; k < 3; k++) begin
      s = prod_q[k][0] + prod_q[k][1] + prod_q[k][2];
      r = rnd_shift(s);
      for (int j = 0; j < 3; j++) begin
        rows_f_d[k][j] = axes_e_q[k][j];
      end
      rows_f_d[k][3] = sat_word(-r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
    end else if (adv) begin
      vld_d_q <= x_vld;
      vld_e_q <= vld_d_q;
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      axes_q   <= axes_d;
      eye_d_q  <= xs.eye;
      deg_d_q  <= ~x_ok | ~xs.z_ok;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[k][j] <= $signed(axes_q[k][j]) * $signed(eye_d_q[j]);
        end
      end
      axes_e_q <= axes_q;
      deg_e_q  <= deg_d_q;
      rows_f_q <= rows_f_d;
      deg_f_q  <= deg_e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= ROW_RIGHT;
    end else if (load) begin
      ser_vld_q <= 1'b1;
      cnt_q     <= ROW_RIGHT;
    end else if (ser_done) begin
      ser_vld_q <= 1'b0;
    end else if (out_fire) begin
      cnt_q     <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ser_rows_q <= deg_f_q ? '0 : rows_f_q;
      ser_deg_q  <= deg_f_q;
    end
  end

  assign out_valid_o           = ser_vld_q;
  assign out_data_o.row_index  = cnt_q;
  assign out_data_o.col0       = ser_rows_q[cnt_q][0];
  assign out_data_o.col1       = ser_rows_q[cnt_q][1];
  assign out_data_o.col2       = ser_rows_q[cnt_q][2];
  assign out_data_o.col3       = ser_rows_q[cnt_q][3];
  assign out_data_o.last       = (cnt_q == ROW_BACK);
  assign out_data_o.degenerate = ser_deg_q;

endmodule

>>> rtl/lav_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the look-at view matrix top level, with its bind.
// Uses lav_pkg.
module lav_chk import lav_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input lav_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input lav_out_t out_data_o
);

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.row_index == ROW_BACK)))
    else $error("last flag does not match the back row");

  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last) |=>
      (out_valid_o && out_data_o.row_index == $past(out_data_o.row_index) + 2'd1))
    else $error("row beats of one request are not contiguous");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.col0 == '0 && out_data_o.col1 == '0 &&
       out_data_o.col2 == '0 && out_data_o.col3 == '0))
    else $error("degenerate row carries nonzero columns");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

endmodule

bind look_at_view_matrix_top lav_chk u_lav_chk (.*);

>>> bench/look_at_view_matrix_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for look_at_view_matrix_top: drives look-at requests and
// checks every matrix row beat against an in-bench fixed-point predictor.
module look_at_view_matrix_top_test;
  import lav_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam longint FB = FRAC_BITS;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lav_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lav_out_t out_data;

  lav_out_t expected_rows[$];
  int mismatches = 0;
  int rows_checked = 0;
  int items_sent = 0;
  int degenerate_seen = 0;
  int idle_cycles = 0;
  bit hold_sink = 1'b0;
  bit no_idle = 1'b0;

  look_at_view_matrix_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_frac(input longint v);
    return v >>> FB;
  endfunction

  function automatic longint round_frac(input longint v);
    return floor_frac(v + (64'sd1 <<< (FB - 1)));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit scale_dir(input longint v[3], output longint unsigned m[3],
                                   output bit ng[3]);
    longint unsigned mx;
    int n;
    mx = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = v[i] < 0;
      m[i] = ng[i] ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (n < 64 && (mx >> n) != 0) n++;
    for (int i = 0; i < 3; i++) begin
      if (n > NORM_BITS) m[i] = m[i] >> (n - NORM_BITS);
      else m[i] = m[i] << (NORM_BITS - n);
    end
    return 1'b1;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned len;
    longint unsigned q;
    bit ng[3];
    o = '{0, 0, 0};
    if (!scale_dir(v, m, ng)) return 1'b0;
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      o[i] = sat32(ng[i] ? -longint'(q) : longint'(q));
    end
    return 1'b1;
  endfunction

  function automatic longint eye_offset(input longint ax[3], input longint eye[3]);
    longint hi;
    longint lo;
    longint eh;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      eh = floor_frac(eye[i]);
      hi += ax[i] * eh;
      lo += ax[i] * (eye[i] - (eh <<< FB));
    end
    return sat32(-(hi + round_frac(lo)));
  endfunction

  task automatic predict_rows(input lav_in_t t);
    longint eye[3], dv[3], up[3], zc[3], xc[3], yc[3], cr[3], un[3];
    longint rows[3][4];
    longint unsigned um[3];
    bit ug[3];
    bit degen;
    lav_out_t r;
    eye = '{longint'(t.eye_x), longint'(t.eye_y), longint'(t.eye_z)};
    dv = '{longint'(t.eye_x) - longint'(t.target_x),
           longint'(t.eye_y) - longint'(t.target_y),
           longint'(t.eye_z) - longint'(t.target_z)};
    up = '{longint'(t.up_x), longint'(t.up_y), longint'(t.up_z)};
    degen = !unit_vec(dv, zc);
    if (!degen) begin
      if (!scale_dir(up, um, ug)) begin
        degen = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) un[i] = ug[i] ? -longint'(um[i]) : longint'(um[i]);
        cr[0] = un[1] * zc[2] - un[2] * zc[1];
        cr[1] = un[2] * zc[0] - un[0] * zc[2];
        cr[2] = un[0] * zc[1] - un[1] * zc[0];
        degen = !unit_vec(cr, xc);
      end
    end
    for (int k = 0; k < 3; k++) for (int i = 0; i < 4; i++) rows[k][i] = 0;
    if (!degen) begin
      yc[0] = sat32(round_frac(zc[1] * xc[2] - zc[2] * xc[1]));
      yc[1] = sat32(round_frac(zc[2] * xc[0] - zc[0] * xc[2]));
      yc[2] = sat32(round_frac(zc[0] * xc[1] - zc[1] * xc[0]));
      for (int i = 0; i < 3; i++) begin
        rows[0][i] = xc[i];
        rows[1][i] = yc[i];
        rows[2][i] = zc[i];
      end
      rows[0][3] = eye_offset(xc, eye);
      rows[1][3] = eye_offset(yc, eye);
      rows[2][3] = eye_offset(zc, eye);
    end
    if (degen) degenerate_seen++;
    for (int k = 0; k < 3; k++) begin
      r.row_index = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_BACK;
      r.col0 = rows[k][0][WORD_BITS-1:0];
      r.col1 = rows[k][1][WORD_BITS-1:0];
      r.col2 = rows[k][2][WORD_BITS-1:0];
      r.col3 = rows[k][3][WORD_BITS-1:0];
      r.last = (k == 2);
      r.degenerate = degen;
      expected_rows.push_back(r);
    end
  endtask

  task automatic send_request(input lav_in_t t);
    while (!no_idle && $urandom_range(99) < 15) @(negedge clk);
    in_valid = 1'b1;
    in_data = t;
    predict_rows(t);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_coords(input longint e[3], input longint g[3], input longint u[3]);
    lav_in_t t;
    t = '{word_t'(e[0]), word_t'(e[1]), word_t'(e[2]),
          word_t'(g[0]), word_t'(g[1]), word_t'(g[2]),
          word_t'(u[0]), word_t'(u[1]), word_t'(u[2])};
    send_request(t);
  endtask

  task automatic wait_drained();
    while (expected_rows.size() != 0) @(negedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t small_word();
    return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
  endfunction

  task automatic test_directed();
    longint one;
    one = 64'sd1 <<< FB;
    send_coords('{0, 0, 5 * one}, '{0, 0, 0}, '{0, one, 0});
    send_coords('{one, 2 * one, 3 * one}, '{one, 2 * one, 3 * one}, '{0, one, 0});
    send_coords('{0, 0, one}, '{0, 0, 0}, '{0, 0, 0});
    send_coords('{0, 4 * one, 0}, '{0, 0, 0}, '{0, 3 * one, 0});
    send_coords('{0, 4 * one, 0}, '{0, 0, 0}, '{0, -one, 0});
    send_coords('{2147483647, 2147483647, 2147483647},
                '{-2147483648, -2147483648, -2147483648}, '{0, one, 0});
    send_coords('{-2147483648, -2147483648, -2147483648},
                '{2147483647, 2147483647, 2147483647}, '{1, 0, 0});
    send_coords('{2147483647, -2147483648, 2147483647}, '{0, 0, 0},
                '{-2147483648, 2147483647, -2147483648});
    send_coords('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
    send_coords('{-2147483648, 0, 0}, '{2147483647, 1, 0}, '{0, 0, 2147483647});
    send_coords('{3 * one, 7 * one, -2 * one}, '{-one, 0, one}, '{one, one, one});
    send_coords('{-1, -1, -1}, '{0, 0, 0}, '{-1, 0, 1});
    send_coords('{2147483647, 0, 0}, '{0, 0, 0}, '{0, 0, -1});
    send_coords('{0, 0, -2147483648}, '{0, 0, 0}, '{-2147483648, 0, 0});
    wait_drained();
  endtask

  task automatic test_random(input int count, input bit wide);
    lav_in_t t;
    for (int n = 0; n < count; n++) begin
      if (wide || $urandom_range(3) == 0) begin
        t = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word()};
      end else begin
        t = '{small_word(), small_word(), small_word(), small_word(), small_word(),
              small_word(), small_word(), small_word(), small_word()};
      end
      if ($urandom_range(19) == 0) begin
        t.target_x = t.eye_x;
        t.target_y = t.eye_y;
        t.target_z = t.eye_z;
      end else if ($urandom_range(19) == 0) begin
        t.up_x = t.eye_x - t.target_x;
        t.up_y = t.eye_y - t.target_y;
        t.up_z = t.eye_z - t.target_z;
      end
      send_request(t);
    end
  endtask

  task automatic test_back_pressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_sink = 1'b0;
      end
      test_random(150, 1'b0);
    join
    wait_drained();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random(60, 1'b1);
    no_idle = 1'b0;
    wait_drained();
  endtask

  always @(negedge clk) begin
    out_ready <= !hold_sink && (no_idle || $urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected row beat %p", out_data);
      end else begin
        if (out_data !== expected_rows[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Row beat mismatch: expected %p", expected_rows[0]);
            $display("                   actual   %p", out_data);
          end
        end
        void'(expected_rows.pop_front());
        rows_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Watchdog expired with %0d row beats pending.", expected_rows.size());
      $display("FAIL look_at_view_matrix_top");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(100, 1'b0);
    test_back_pressure();
    test_no_idle();
    test_random(55, 1'b1);
    wait_drained();
    repeat (300) @(negedge clk);
    $display("Sent %0d requests and checked %0d row beats, %0d degenerate cases.",
             items_sent, rows_checked, degenerate_seen);
    $display("Covered extreme words, degenerate inputs, stalls and pauses.");
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS look_at_view_matrix_top");
    end else begin
      $display("%0d mismatches, %0d rows left.", mismatches, expected_rows.size());
      $display("FAIL look_at_view_matrix_top");
    end
    $finish;
  end

endmodule
